// ----- rtl/cljadm_pkg.sv -----
// Shared definitions for the job admitter: operation and outcome codes,
// widths, parameter defaults and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package cljadm_pkg;

	// Fixed field widths
	localparam int unsigned OP_W      = 3;
	localparam int unsigned TAG_W     = 16;
	localparam int unsigned HANDLE_W  = 16;
	localparam int unsigned RUN_W     = 8;
	localparam int unsigned OUTCOME_W = 3;

	// Parameter defaults
	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned TAG_BITS_DEF    = 16;

	// Reset value of the concurrency limit
	localparam logic [RUN_W-1:0] MAX_RUNNING_RST = 8'd4;

	// Operation codes
	localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd0;
	localparam logic [OP_W-1:0] OP_DONE     = 3'd1;
	localparam logic [OP_W-1:0] OP_CANCEL   = 3'd2;
	localparam logic [OP_W-1:0] OP_SUSPEND  = 3'd3;
	localparam logic [OP_W-1:0] OP_RESUME   = 3'd4;

	// Outcome codes
	localparam logic [OUTCOME_W-1:0] OUT_STARTED      = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_QUEUED       = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_NOTHING      = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_CANCELLED    = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_NOT_QUEUED   = 3'd4;
	localparam logic [OUTCOME_W-1:0] OUT_FULL         = 3'd5;
	localparam logic [OUTCOME_W-1:0] OUT_NONE_RUNNING = 3'd6;
	localparam logic [OUTCOME_W-1:0] OUT_ACK          = 3'd7;

	// Commands from controller to datapath
	typedef struct packed {
		logic                 cap_item;   // latch request fields, clear result tag and handle
		logic                 run_inc;
		logic                 run_dec;
		logic                 push;       // write top of stack, take a handle
		logic                 set_susp;
		logic                 clr_susp;
		logic                 pop;        // drop top entry, read its tag
		logic                 can_init;   // search index <= stack count
		logic                 can_step;   // search index--, read its handle
		logic                 can_mark;   // mark entry at search index
		logic                 set_res;
		logic [OUTCOME_W-1:0] res_code;
		logic                 start_tag;  // started tag from request
		logic                 start_mem;  // started tag from stack read
		logic                 out_load;   // move result to output register
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            suspended;
		logic            can_start;
		logic            full;
		logic            run_zero;
		logic            run_max;
		logic            count_zero;
		logic            top_cancelled;
		logic            idx_zero;
		logic            handle_match;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/concurrency_limited_job_admitter.sv -----
// Top level of the job admitter: controller plus datapath.
// Depends on cljadm_pkg, cljadm_ctrl and cljadm_dp.
//
// Admits job tags under the max_running limit, parking the rest on a LIFO
// pending stack of QUEUE_DEPTH entries. One item is worked at a time; the
// result goes to an output register, so the next item can be accepted while
// it waits. Schedule, suspend, unknown ops, a done with none running or while
// suspended and a resume while not suspended go from dispatch straight to
// the finish state. A done or resume that tries to start a job pops stack
// entries one at a time, then reads the tag from the stack memory, or ends
// the walk on an empty stack or a running count at its 8-bit ceiling. Cancel
// walks the stack from the top, a memory read and then a handle compare per
// entry, with a final check when no handle matches. A result still held by a
// stalled output delays the next accept. No clearing pass after reset.
// max_running may be written only while idle.
`default_nettype none

module concurrency_limited_job_admitter #(
	parameter int unsigned QUEUE_DEPTH = cljadm_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned TAG_BITS    = cljadm_pkg::TAG_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [cljadm_pkg::RUN_W-1:0]         cfg_wr_data,
	input  wire logic                                 req_valid,
	output logic                                      req_stall,
	input  wire logic [cljadm_pkg::OP_W-1:0]          op,
	input  wire logic [cljadm_pkg::TAG_W-1:0]         job_tag,
	input  wire logic [cljadm_pkg::HANDLE_W-1:0]      cancel_handle,
	output logic                                      rsp_valid,
	input  wire logic                                 rsp_stall,
	output logic      [cljadm_pkg::OUTCOME_W-1:0]     outcome,
	output logic      [cljadm_pkg::TAG_W-1:0]         started_tag,
	output logic      [cljadm_pkg::HANDLE_W-1:0]      queue_handle,
	output logic      [cljadm_pkg::RUN_W-1:0]         running_count
);

	cljadm_pkg::dp_cmd_t  cmd;
	cljadm_pkg::dp_stat_t stat;

	cljadm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	cljadm_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.op            (op),
		.job_tag       (job_tag),
		.cancel_handle (cancel_handle),
		.cmd           (cmd),
		.stat          (stat),
		.outcome       (outcome),
		.started_tag   (started_tag),
		.queue_handle  (queue_handle),
		.running_count (running_count)
	);

endmodule

`default_nettype wire

// ----- rtl/cljadm_dp.sv -----
// Datapath of the job admitter: counters, pending stack memories, cancel
// marks, result and output registers. Driven by cljadm_ctrl commands.
// Depends on cljadm_pkg.
`default_nettype none

module cljadm_dp #(
	parameter int unsigned QUEUE_DEPTH = cljadm_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned TAG_BITS    = cljadm_pkg::TAG_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [cljadm_pkg::RUN_W-1:0]         cfg_wr_data,
	input  wire logic [cljadm_pkg::OP_W-1:0]          op,
	input  wire logic [cljadm_pkg::TAG_W-1:0]         job_tag,
	input  wire logic [cljadm_pkg::HANDLE_W-1:0]      cancel_handle,
	input  wire cljadm_pkg::dp_cmd_t                  cmd,
	output cljadm_pkg::dp_stat_t                      stat,
	output logic      [cljadm_pkg::OUTCOME_W-1:0]     outcome,
	output logic      [cljadm_pkg::TAG_W-1:0]         started_tag,
	output logic      [cljadm_pkg::HANDLE_W-1:0]      queue_handle,
	output logic      [cljadm_pkg::RUN_W-1:0]         running_count
);

	// Stored tag width: tags keep their low TAG_BITS bits of the 16-bit field
	localparam int unsigned TW = (TAG_BITS < cljadm_pkg::TAG_W) ? TAG_BITS : cljadm_pkg::TAG_W;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned IW = $clog2(QUEUE_DEPTH);
	localparam int unsigned HW = cljadm_pkg::HANDLE_W;
	localparam int unsigned RW = cljadm_pkg::RUN_W;

	// Control state
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          idx_q;
	logic [RW-1:0]          run_q;
	logic [RW-1:0]          max_q;
	logic                   susp_q;
	logic [HW-1:0]          next_hdl_q;
	logic [QUEUE_DEPTH-1:0] cancel_q;

	// Latched request fields
	logic [cljadm_pkg::OP_W-1:0] op_q;
	logic [TW-1:0]               tag_q;
	logic [HW-1:0]               chandle_q;

	// Pending stack storage and registered read data
	logic [TW-1:0] tag_mem [QUEUE_DEPTH];
	logic [HW-1:0] hdl_mem [QUEUE_DEPTH];
	logic [TW-1:0] tag_rd_q;
	logic [HW-1:0] hdl_rd_q;

	// Result being built, then output register
	logic [cljadm_pkg::OUTCOME_W-1:0] res_code_q;
	logic [cljadm_pkg::TAG_W-1:0]     res_start_q;
	logic [HW-1:0]                    res_qh_q;
	logic [cljadm_pkg::OUTCOME_W-1:0] outcome_q;
	logic [cljadm_pkg::TAG_W-1:0]     started_q;
	logic [HW-1:0]                    qhandle_q;
	logic [RW-1:0]                    running_q;

	// Stack addressing
	logic [CW-1:0] top_cnt;
	logic [CW-1:0] idx_dec;
	logic [IW-1:0] wr_idx;
	logic [IW-1:0] top_idx;
	logic [IW-1:0] rd_idx;

	assign top_cnt = count_q - CW'(1);
	assign idx_dec = idx_q - CW'(1);
	assign wr_idx  = count_q[IW-1:0];
	assign top_idx = top_cnt[IW-1:0];
	assign rd_idx  = cmd.pop ? top_idx : idx_dec[IW-1:0];

	// Counters, flags and cancel marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			idx_q      <= '0;
			run_q      <= '0;
			max_q      <= cljadm_pkg::MAX_RUNNING_RST;
			susp_q     <= 1'b0;
			next_hdl_q <= '0;
			cancel_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			if (cmd.push) begin
				count_q          <= count_q + CW'(1);
				next_hdl_q       <= next_hdl_q + HW'(1);
				cancel_q[wr_idx] <= 1'b0;
			end else if (cmd.pop) begin
				count_q <= top_cnt;
			end
			if (cmd.can_mark) begin
				cancel_q[idx_q[IW-1:0]] <= 1'b1;
			end
			if (cmd.can_init) begin
				idx_q <= count_q;
			end else if (cmd.can_step) begin
				idx_q <= idx_dec;
			end
			if (cmd.run_inc) begin
				run_q <= run_q + RW'(1);
			end else if (cmd.run_dec) begin
				run_q <= run_q - RW'(1);
			end
			if (cmd.set_susp) begin
				susp_q <= 1'b1;
			end else if (cmd.clr_susp) begin
				susp_q <= 1'b0;
			end
		end
	end

	// Stack memories: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			tag_mem[wr_idx] <= tag_q;
			hdl_mem[wr_idx] <= next_hdl_q;
		end
		if (cmd.pop || cmd.can_step) begin
			tag_rd_q <= tag_mem[rd_idx];
			hdl_rd_q <= hdl_mem[rd_idx];
		end
	end

	// Request capture, result build and output register
	always_ff @(posedge clk) begin
		if (cmd.cap_item) begin
			op_q        <= op;
			tag_q       <= job_tag[TW-1:0];
			chandle_q   <= cancel_handle;
			res_start_q <= '0;
			res_qh_q    <= '0;
		end
		if (cmd.set_res) begin
			res_code_q <= cmd.res_code;
		end
		if (cmd.start_tag) begin
			res_start_q <= cljadm_pkg::TAG_W'(tag_q);
		end else if (cmd.start_mem) begin
			res_start_q <= cljadm_pkg::TAG_W'(tag_rd_q);
		end
		if (cmd.push) begin
			res_qh_q <= next_hdl_q;
		end
		if (cmd.out_load) begin
			outcome_q <= res_code_q;
			started_q <= res_start_q;
			qhandle_q <= res_qh_q;
			running_q <= run_q;
		end
	end

	// Status to controller
	always_comb begin
		stat               = '0;
		stat.op            = op_q;
		stat.suspended     = susp_q;
		stat.can_start     = !susp_q && (run_q < max_q);
		stat.full          = (count_q == CW'(QUEUE_DEPTH));
		stat.run_zero      = (run_q == '0);
		stat.run_max       = (run_q == '1);
		stat.count_zero    = (count_q == '0);
		stat.top_cancelled = cancel_q[top_idx];
		stat.idx_zero      = (idx_q == '0);
		stat.handle_match  = (hdl_rd_q == chandle_q);
	end

	assign outcome       = outcome_q;
	assign started_tag   = started_q;
	assign queue_handle  = qhandle_q;
	assign running_count = running_q;

	// Stack never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("pending count above depth");

	// Push only into a stack with room
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !stat.full)
		else $error("push into full stack");

	// A cancel mark lands on a live entry
	a_mark_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.can_mark |-> (idx_q < count_q))
		else $error("cancel mark outside stack");

endmodule

`default_nettype wire

// ----- rtl/cljadm_ctrl.sv -----
// Controller of the job admitter: takes one item at a time, sequences the
// datapath through the operation and hands the result to the output.
// Depends on cljadm_pkg.
`default_nettype none

module cljadm_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	input  wire cljadm_pkg::dp_stat_t stat,
	output cljadm_pkg::dp_cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DISP    = 3'd1;
	localparam logic [2:0] ST_POP     = 3'd2;
	localparam logic [2:0] ST_POP_TAG = 3'd3;
	localparam logic [2:0] ST_CAN_RD  = 3'd4;
	localparam logic [2:0] ST_CAN_CMP = 3'd5;
	localparam logic [2:0] ST_FIN     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       out_ok;

	// Output slot free, or its item leaves this cycle
	assign out_ok    = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.cap_item = 1'b1;
					state_d      = ST_DISP;
				end
			end
			ST_DISP: begin
				cmd.set_res = 1'b1;
				state_d     = ST_FIN;
				unique case (stat.op)
					cljadm_pkg::OP_SCHEDULE: begin
						if (stat.can_start) begin
							cmd.run_inc   = 1'b1;
							cmd.start_tag = 1'b1;
							cmd.res_code  = cljadm_pkg::OUT_STARTED;
						end else if (stat.full) begin
							cmd.res_code = cljadm_pkg::OUT_FULL;
						end else begin
							cmd.push     = 1'b1;
							cmd.res_code = cljadm_pkg::OUT_QUEUED;
						end
					end
					cljadm_pkg::OP_DONE: begin
						if (stat.run_zero) begin
							cmd.res_code = cljadm_pkg::OUT_NONE_RUNNING;
						end else begin
							cmd.run_dec  = 1'b1;
							cmd.res_code = cljadm_pkg::OUT_NOTHING;
							if (!stat.suspended) begin
								state_d = ST_POP;
							end
						end
					end
					cljadm_pkg::OP_CANCEL: begin
						cmd.can_init = 1'b1;
						cmd.res_code = cljadm_pkg::OUT_NOT_QUEUED;
						state_d      = ST_CAN_RD;
					end
					cljadm_pkg::OP_SUSPEND: begin
						cmd.set_susp = 1'b1;
						cmd.res_code = cljadm_pkg::OUT_ACK;
					end
					cljadm_pkg::OP_RESUME: begin
						cmd.res_code = cljadm_pkg::OUT_NOTHING;
						if (stat.suspended) begin
							cmd.clr_susp = 1'b1;
							state_d      = ST_POP;
						end
					end
					default: begin
						cmd.res_code = cljadm_pkg::OUT_ACK;
					end
				endcase
			end
			// Pop from the top until a live entry turns up, the stack is empty or the running count is at its ceiling
			ST_POP: begin
				if (stat.run_max || stat.count_zero) begin
					state_d = ST_FIN;
				end else begin
					cmd.pop = 1'b1;
					if (!stat.top_cancelled) begin
						state_d = ST_POP_TAG;
					end
				end
			end
			ST_POP_TAG: begin
				cmd.run_inc   = 1'b1;
				cmd.start_mem = 1'b1;
				cmd.set_res   = 1'b1;
				cmd.res_code  = cljadm_pkg::OUT_STARTED;
				state_d       = ST_FIN;
			end
			// Handle search from the top, read then compare
			ST_CAN_RD: begin
				if (stat.idx_zero) begin
					state_d = ST_FIN;
				end else begin
					cmd.can_step = 1'b1;
					state_d      = ST_CAN_CMP;
				end
			end
			ST_CAN_CMP: begin
				if (stat.handle_match) begin
					cmd.can_mark = 1'b1;
					cmd.set_res  = 1'b1;
					cmd.res_code = cljadm_pkg::OUT_CANCELLED;
					state_d      = ST_FIN;
				end else begin
					state_d = ST_CAN_RD;
				end
			end
			ST_FIN: begin
				if (out_ok) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// An accepted item keeps the request side stalled next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request side not stalled after accept");

	// A finished result waits while the output is stalled
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && rsp_valid_q && rsp_stall) |=> (state_q == ST_FIN))
		else $error("result left while output stalled");

	// Pops only from a non-empty stack and below the running ceiling
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (!stat.count_zero && !stat.run_max))
		else $error("pop from empty stack or at running limit");

endmodule

`default_nettype wire

// ----- dv/tb_concurrency_limited_job_admitter.sv -----
// Self-checking testbench for concurrency_limited_job_admitter: directed table, random
// operation mixes under several concurrency limits, and a run up to the running ceiling.
// Depends on cljadm_pkg and the admitter RTL only.
module tb_concurrency_limited_job_admitter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH      = cljadm_pkg::QUEUE_DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 40;
	localparam int DIR_N       = 25;

	// op codes the block treats as no-ops
	localparam logic [cljadm_pkg::OP_W-1:0] OP_RSVD_LO  = 3'd5;
	localparam logic [cljadm_pkg::OP_W-1:0] OP_RSVD_MID = 3'd6;
	localparam logic [cljadm_pkg::OP_W-1:0] OP_RSVD_HI  = 3'd7;

	typedef struct packed {
		logic [cljadm_pkg::OUTCOME_W-1:0] outcome;
		logic [cljadm_pkg::TAG_W-1:0]     tag;
		logic [cljadm_pkg::HANDLE_W-1:0]  hdl;
		logic [cljadm_pkg::RUN_W-1:0]     run;
	} admit_rsp_t;

	typedef struct packed {
		logic [cljadm_pkg::OP_W-1:0]     op;
		logic [cljadm_pkg::TAG_W-1:0]    tag;
		logic [cljadm_pkg::HANDLE_W-1:0] hdl;
		logic                            typed;
		admit_rsp_t                      want;
	} dir_row_t;

	localparam admit_rsp_t NO_RSP = '0;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [cljadm_pkg::RUN_W-1:0]     cfg_wr_data;
	logic                             req_valid;
	logic                             req_stall;
	logic [cljadm_pkg::OP_W-1:0]      op;
	logic [cljadm_pkg::TAG_W-1:0]     job_tag;
	logic [cljadm_pkg::HANDLE_W-1:0]  cancel_handle;
	logic                             rsp_valid;
	logic                             rsp_stall;
	logic [cljadm_pkg::OUTCOME_W-1:0] outcome;
	logic [cljadm_pkg::TAG_W-1:0]     started_tag;
	logic [cljadm_pkg::HANDLE_W-1:0]  queue_handle;
	logic [cljadm_pkg::RUN_W-1:0]     running_count;

	// predictor state
	logic [cljadm_pkg::TAG_W-1:0]    stk_tag [QDEPTH];
	logic [cljadm_pkg::HANDLE_W-1:0] stk_hdl [QDEPTH];
	logic                            stk_cxl [QDEPTH];
	int                              stk_cnt;
	int                              run_cnt;
	logic                            susp;
	logic [cljadm_pkg::HANDLE_W-1:0] nxt_hdl;
	logic [cljadm_pkg::RUN_W-1:0]    lim;

	admit_rsp_t rsp_due_q [$];
	int         n_bad;
	logic       calm;

	// directed items; expectations typed in where they are obvious
	dir_row_t dir_tab [0:DIR_N-1] = '{
		'{cljadm_pkg::OP_DONE, 16'h0000, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_NONE_RUNNING, 16'h0, 16'h0, 8'd0}},
		'{cljadm_pkg::OP_RESUME, 16'h0000, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_NOTHING, 16'h0, 16'h0, 8'd0}},
		'{cljadm_pkg::OP_CANCEL, 16'h0000, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_NOT_QUEUED, 16'h0, 16'h0, 8'd0}},
		'{OP_RSVD_LO, 16'h0000, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_ACK, 16'h0, 16'h0, 8'd0}},
		'{OP_RSVD_HI, 16'hFFFF, 16'hFFFF, 1'b1,
			'{cljadm_pkg::OUT_ACK, 16'h0, 16'h0, 8'd0}},
		'{cljadm_pkg::OP_SCHEDULE, 16'hFFFF, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_STARTED, 16'hFFFF, 16'h0, 8'd1}},
		'{cljadm_pkg::OP_SCHEDULE, 16'h0000, 16'hFFFF, 1'b1,
			'{cljadm_pkg::OUT_STARTED, 16'h0000, 16'h0, 8'd2}},
		'{cljadm_pkg::OP_SCHEDULE, 16'h0F0F, 16'h0000, 1'b0, NO_RSP},
		'{cljadm_pkg::OP_SCHEDULE, 16'hF0F0, 16'h0000, 1'b0, NO_RSP},
		'{cljadm_pkg::OP_SCHEDULE, 16'hAAAA, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_QUEUED, 16'h0, 16'h0000, 8'd4}},
		'{cljadm_pkg::OP_SCHEDULE, 16'h5555, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_QUEUED, 16'h0, 16'h0001, 8'd4}},
		'{cljadm_pkg::OP_SCHEDULE, 16'h1234, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_QUEUED, 16'h0, 16'h0002, 8'd4}},
		'{cljadm_pkg::OP_CANCEL, 16'h0000, 16'h0001, 1'b1,
			'{cljadm_pkg::OUT_CANCELLED, 16'h0, 16'h0, 8'd4}},
		'{cljadm_pkg::OP_CANCEL, 16'h0000, 16'h0001, 1'b1,
			'{cljadm_pkg::OUT_CANCELLED, 16'h0, 16'h0, 8'd4}},
		'{cljadm_pkg::OP_CANCEL, 16'h0000, 16'hFFFF, 1'b1,
			'{cljadm_pkg::OUT_NOT_QUEUED, 16'h0, 16'h0, 8'd4}},
		'{cljadm_pkg::OP_DONE, 16'h0000, 16'h0000, 1'b0, NO_RSP},
		'{cljadm_pkg::OP_DONE, 16'h0000, 16'h0000, 1'b0, NO_RSP},
		'{cljadm_pkg::OP_SUSPEND, 16'h0000, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_ACK, 16'h0, 16'h0, 8'd4}},
		'{cljadm_pkg::OP_SUSPEND, 16'h0000, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_ACK, 16'h0, 16'h0, 8'd4}},
		'{cljadm_pkg::OP_SCHEDULE, 16'hBEEF, 16'h0000, 1'b0, NO_RSP},
		'{cljadm_pkg::OP_DONE, 16'h0000, 16'h0000, 1'b0, NO_RSP},
		'{cljadm_pkg::OP_RESUME, 16'h0000, 16'h0000, 1'b0, NO_RSP},
		'{cljadm_pkg::OP_RESUME, 16'h0000, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_NOTHING, 16'h0, 16'h0, 8'd4}},
		'{cljadm_pkg::OP_DONE, 16'h0000, 16'h0000, 1'b0, NO_RSP},
		'{OP_RSVD_MID, 16'h0000, 16'h0000, 1'b1,
			'{cljadm_pkg::OUT_ACK, 16'h0, 16'h0, 8'd3}}
	};

	concurrency_limited_job_admitter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.op            (op),
		.job_tag       (job_tag),
		.cancel_handle (cancel_handle),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.outcome       (outcome),
		.started_tag   (started_tag),
		.queue_handle  (queue_handle),
		.running_count (running_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Pop from the top past cancelled entries and start the first live one
	function automatic logic pop_to_start(output logic [cljadm_pkg::TAG_W-1:0] tg);
		tg = '0;
		if (run_cnt >= 255)
			return 1'b0;
		while (stk_cnt > 0) begin
			stk_cnt--;
			if (!stk_cxl[stk_cnt]) begin
				tg = stk_tag[stk_cnt];
				run_cnt++;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Expected result of one accepted item; advances the predictor state
	function automatic admit_rsp_t admit_predict(input logic [cljadm_pkg::OP_W-1:0] o,
			input logic [cljadm_pkg::TAG_W-1:0] t,
			input logic [cljadm_pkg::HANDLE_W-1:0] h);
		admit_rsp_t                   r;
		logic [cljadm_pkg::TAG_W-1:0] tg;
		int                           i;
		r = '0;
		r.outcome = cljadm_pkg::OUT_ACK;
		case (o)
			cljadm_pkg::OP_SCHEDULE: begin
				if (!susp && run_cnt < lim) begin
					run_cnt++;
					r.outcome = cljadm_pkg::OUT_STARTED;
					r.tag = t;
				end else if (stk_cnt >= QDEPTH) begin
					r.outcome = cljadm_pkg::OUT_FULL;
				end else begin
					stk_tag[stk_cnt] = t;
					stk_hdl[stk_cnt] = nxt_hdl;
					stk_cxl[stk_cnt] = 1'b0;
					stk_cnt++;
					r.outcome = cljadm_pkg::OUT_QUEUED;
					r.hdl = nxt_hdl;
					nxt_hdl++;
				end
			end
			cljadm_pkg::OP_DONE: begin
				if (run_cnt == 0) begin
					r.outcome = cljadm_pkg::OUT_NONE_RUNNING;
				end else begin
					run_cnt--;
					r.outcome = cljadm_pkg::OUT_NOTHING;
					if (!susp && pop_to_start(tg)) begin
						r.outcome = cljadm_pkg::OUT_STARTED;
						r.tag = tg;
					end
				end
			end
			cljadm_pkg::OP_CANCEL: begin
				r.outcome = cljadm_pkg::OUT_NOT_QUEUED;
				for (i = stk_cnt - 1; i >= 0; i--) begin
					if (stk_hdl[i] == h) begin
						stk_cxl[i] = 1'b1;
						r.outcome = cljadm_pkg::OUT_CANCELLED;
						break;
					end
				end
			end
			cljadm_pkg::OP_SUSPEND: begin
				susp = 1'b1;
			end
			cljadm_pkg::OP_RESUME: begin
				r.outcome = cljadm_pkg::OUT_NOTHING;
				if (susp) begin
					susp = 1'b0;
					if (pop_to_start(tg)) begin
						r.outcome = cljadm_pkg::OUT_STARTED;
						r.tag = tg;
					end
				end
			end
			default: r.outcome = cljadm_pkg::OUT_ACK;
		endcase
		r.run = cljadm_pkg::RUN_W'(run_cnt);
		return r;
	endfunction

	// Present one item, wait for its acceptance, record what must come back
	task automatic issue_req(input logic [cljadm_pkg::OP_W-1:0] o,
			input logic [cljadm_pkg::TAG_W-1:0] t,
			input logic [cljadm_pkg::HANDLE_W-1:0] h, input logic typed,
			input admit_rsp_t want);
		admit_rsp_t p;
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		req_valid <= 1'b1;
		op <= o;
		job_tag <= t;
		cancel_handle <= h;
		do @(posedge clk); while (req_stall);
		p = admit_predict(o, t, h);
		rsp_due_q.push_back(typed ? want : p);
		@(negedge clk);
	endtask

	task automatic issue(input logic [cljadm_pkg::OP_W-1:0] o,
			input logic [cljadm_pkg::TAG_W-1:0] t,
			input logic [cljadm_pkg::HANDLE_W-1:0] h);
		issue_req(o, t, h, 1'b0, NO_RSP);
	endtask

	// Hold off the sender until every outstanding result is back
	task automatic drain_rsps();
		req_valid <= 1'b0;
		do @(negedge clk); while (rsp_due_q.size() != 0);
	endtask

	task automatic set_limit(input logic [cljadm_pkg::RUN_W-1:0] v);
		drain_rsps();
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		lim = v;
		@(negedge clk);
	endtask

	// Random operation mix; cancels mostly aim at handles still waiting
	task automatic run_mix(input int n, input int sched_pct);
		int                              r;
		logic [cljadm_pkg::OP_W-1:0]     o;
		logic [cljadm_pkg::HANDLE_W-1:0] h;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < sched_pct)
				o = cljadm_pkg::OP_SCHEDULE;
			else if (r < 72)
				o = cljadm_pkg::OP_DONE;
			else if (r < 87)
				o = cljadm_pkg::OP_CANCEL;
			else if (r < 92)
				o = cljadm_pkg::OP_SUSPEND;
			else if (r < 98)
				o = cljadm_pkg::OP_RESUME;
			else
				o = cljadm_pkg::OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
			r = $urandom_range(0, 9);
			if (stk_cnt > 0 && r < 7)
				h = stk_hdl[$urandom_range(0, stk_cnt - 1)];
			else if (r < 8)
				h = nxt_hdl;
			else
				h = cljadm_pkg::HANDLE_W'($urandom());
			issue(o, cljadm_pkg::TAG_W'($urandom()), h);
			if (!calm && $urandom_range(0, 49) == 0)
				drain_rsps();
		end
	endtask

	// Receiver: stall bursts with quiet stretches in between
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(30, 80)) @(negedge clk);
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// Result checker: compare each accepted result with the oldest expectation
	always @(posedge clk) begin : rsp_chk
		admit_rsp_t got;
		admit_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = {outcome, started_tag, queue_handle, running_count};
			if (rsp_due_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("unexpected result: outcome=%0d tag=%h handle=%h running=%0d",
						got.outcome, got.tag, got.hdl, got.run);
			end else begin
				want = rsp_due_q.pop_front();
				if (got !== want) begin
					n_bad++;
					if (n_bad <= 10) begin
						$display("result mismatch: want outcome=%0d tag=%h handle=%h running=%0d",
							want.outcome, want.tag, want.hdl, want.run);
						$display("                 got  outcome=%0d tag=%h handle=%h running=%0d",
							got.outcome, got.tag, got.hdl, got.run);
					end
				end
			end
		end
	end

	// Watchdog: too long without any handshake ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stim
		arst_n = 1'b0;
		req_valid = 1'b0;
		op = cljadm_pkg::OP_SCHEDULE;
		job_tag = '0;
		cancel_handle = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		calm = 1'b0;
		n_bad = 0;
		stk_cnt = 0;
		run_cnt = 0;
		susp = 1'b0;
		nxt_hdl = '0;
		lim = cljadm_pkg::MAX_RUNNING_RST;
		for (int i = 0; i < QDEPTH; i++) begin
			stk_tag[i] = '0;
			stk_hdl[i] = '0;
			stk_cxl[i] = 1'b0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed items at the reset limit
		for (int k = 0; k < DIR_N; k++)
			issue_req(dir_tab[k].op, dir_tab[k].tag, dir_tab[k].hdl, dir_tab[k].typed,
				dir_tab[k].want);

		set_limit(8'd1);
		run_mix(50, 45);

		// zero limit: every schedule queues or finds the stack full; enough schedules to hit a full stack
		set_limit(8'd0);
		repeat (QDEPTH + 1) issue(cljadm_pkg::OP_SCHEDULE, cljadm_pkg::TAG_W'($urandom()), '0);
		run_mix(30, 40);

		set_limit(cljadm_pkg::RUN_W'($urandom_range(3, 254)));
		run_mix(50, 50);

		set_limit(8'd2);
		run_mix(40, 35);

		// widest limit: drive the running count to its ceiling
		set_limit(8'd255);
		if (susp)
			issue(cljadm_pkg::OP_RESUME, '0, '0);
		while (run_cnt < 255)
			issue(cljadm_pkg::OP_SCHEDULE, cljadm_pkg::TAG_W'($urandom()), '0);
		repeat (3) issue(cljadm_pkg::OP_SCHEDULE, cljadm_pkg::TAG_W'($urandom()), '0);
		issue(cljadm_pkg::OP_SUSPEND, '0, '0);
		issue(cljadm_pkg::OP_RESUME, '0, '0);
		issue(cljadm_pkg::OP_DONE, '0, '0);
		issue(cljadm_pkg::OP_SUSPEND, '0, '0);
		issue(cljadm_pkg::OP_DONE, '0, '0);
		issue(cljadm_pkg::OP_RESUME, '0, '0);
		run_mix(20, 30);

		// no idling from here on
		drain_rsps();
		calm = 1'b1;
		set_limit(cljadm_pkg::MAX_RUNNING_RST);
		run_mix(50, 45);

		drain_rsps();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_bad == 0 && rsp_due_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
